[hw/rtl/cpit_pkg.sv]
// Shared types and constants for the child path intern table.
package cpit_pkg;

  localparam int KEY_W        = 32;
  localparam int ID_W         = 16;
  localparam int PATH_CAPACITY = 65536;
  localparam int ID_CNT_W     = ID_W + 1;
  // ids run from 1 up to the smaller of PATH_CAPACITY - 1 and the id field's range
  localparam int ID_LIMIT     = (PATH_CAPACITY < (1 << ID_W)) ? PATH_CAPACITY : (1 << ID_W);
  localparam int SLOT_AW      = 17;
  localparam int SLOTS        = 1 << SLOT_AW;
  localparam int EPOCH_W      = 8;
  localparam logic [KEY_W-1:0] HASH_MULT = 32'd2654435761;

  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    logic [KEY_W-1:0]   key;
    logic [ID_W-1:0]    id;
  } slot_t;

  typedef struct packed {
    logic                we;
    logic [SLOT_AW-1:0]  waddr;
    slot_t               wdata;
    logic                re;
    logic [SLOT_AW-1:0]  raddr;
  } ram_req_t;

  typedef struct packed {
    logic                sweeping;
    logic [ID_CNT_W-1:0] next_id;
  } stat_t;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_WIPE,
    ST_LOOKUP,
    ST_PROBE
  } state_t;

  typedef enum logic {
    REQ_LOOKUP = 1'b0,
    REQ_CLEAR  = 1'b1
  } req_t;

endpackage

[hw/rtl/cpit_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
module cpit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/cpit_hash.sv]
// Registered multiplicative hash from a (parent, segment) key to a home slot.
module cpit_hash (
  input  logic                           clk,
  input  logic                           load,
  input  logic [cpit_pkg::KEY_W-1:0]     key,
  output logic [cpit_pkg::SLOT_AW-1:0]   slot
);
  import cpit_pkg::*;

  logic [KEY_W-1:0] prod;

  assign prod = key * HASH_MULT;

  always_ff @(posedge clk) begin
    if (load) begin
      slot <= prod[KEY_W-1 -: SLOT_AW];
    end
  end

endmodule

[hw/rtl/cpit_probe.sv]
// Probe sequencer: linear probing, insert, epoch clear, sweep and result register.
module cpit_probe (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          req_type,
  input  logic [cpit_pkg::KEY_W-1:0]    key_in,
  input  logic [cpit_pkg::SLOT_AW-1:0]  hash_slot,
  input  cpit_pkg::slot_t               rd_slot,
  output cpit_pkg::ram_req_t            ram_req,
  output cpit_pkg::stat_t               stat,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cpit_pkg::ID_W-1:0]     out_id,
  output logic                          out_created,
  output logic                          out_full
);
  import cpit_pkg::*;

  state_t               state, state_next;
  logic [KEY_W-1:0]     key;
  logic [SLOT_AW-1:0]   pos;
  logic [SLOT_AW-1:0]   sweep_cnt;
  logic [EPOCH_W-1:0]   cur_epoch;
  logic [ID_CNT_W-1:0]  next_id;

  logic empty, hit, finish, out_free, no_room, emit, insert, wipe_go;

  assign empty    = (rd_slot.epoch != cur_epoch);
  assign hit      = !empty && (rd_slot.key == key);
  assign finish   = empty || hit;
  assign out_free = !out_valid || out_ready;
  assign no_room  = (next_id >= ID_CNT_W'(ID_LIMIT));
  assign wipe_go  = (state == ST_WIPE) && out_free;
  assign emit     = wipe_go || ((state == ST_PROBE) && finish && out_free);
  assign insert   = (state == ST_PROBE) && empty && !no_room && out_free;

  assign in_ready = (state == ST_IDLE);
  assign stat     = '{sweeping: (state == ST_SWEEP), next_id: next_id};

  always_comb begin
    state_next = state;
    unique case (state)
      ST_SWEEP:  if (sweep_cnt == SLOT_AW'(SLOTS - 1)) state_next = ST_IDLE;
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (req_type == REQ_CLEAR) ? ST_WIPE : ST_LOOKUP;
        end
      end
      ST_WIPE: begin
        if (out_free) begin
          state_next = (cur_epoch == '1) ? ST_SWEEP : ST_IDLE;
        end
      end
      ST_LOOKUP: state_next = ST_PROBE;
      ST_PROBE:  if (finish && out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ram_req = '0;
    unique case (state)
      ST_SWEEP: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = sweep_cnt;
      end
      ST_LOOKUP: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = hash_slot;
      end
      ST_PROBE: begin
        // collision: read the following slot, result comes back next cycle
        if (!finish) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = pos + 1'b1;
        end
        if (insert) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = pos;
          ram_req.wdata = '{epoch: cur_epoch, key: key, id: next_id[ID_W-1:0]};
        end
      end
      default: ram_req = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_SWEEP;
      sweep_cnt <= '0;
      cur_epoch <= EPOCH_W'(1);
      next_id   <= ID_CNT_W'(1);
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_SWEEP) begin
        sweep_cnt <= sweep_cnt + 1'b1;
      end
      if (wipe_go) begin
        // epoch wraps back to 1; the sweep that follows removes stale marks
        cur_epoch <= (cur_epoch == '1) ? EPOCH_W'(1) : cur_epoch + 1'b1;
        next_id   <= ID_CNT_W'(1);
      end else if (insert) begin
        next_id <= next_id + 1'b1;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      key <= key_in;
    end
    if (state == ST_LOOKUP) begin
      pos <= hash_slot;
    end else if ((state == ST_PROBE) && !finish) begin
      pos <= pos + 1'b1;
    end
    if (emit) begin
      priority if (state == ST_WIPE) begin
        out_id      <= '0;
        out_created <= 1'b0;
        out_full    <= 1'b0;
      end else if (hit) begin
        out_id      <= rd_slot.id;
        out_created <= 1'b0;
        out_full    <= 1'b0;
      end else if (no_room) begin
        out_id      <= '0;
        out_created <= 1'b0;
        out_full    <= 1'b1;
      end else begin
        out_id      <= next_id[ID_W-1:0];
        out_created <= 1'b1;
        out_full    <= 1'b0;
      end
    end
  end

endmodule

[hw/rtl/child_path_intern_table.sv]
// Child path intern table: top level with slot RAM, hash and probe sequencer.
//
// Each lookup item steps through accept and hash, slot read and compare, and probes
// onward slot by slot while the slots from its hash home are taken by other pairs;
// the single read port of the 131072-slot RAM sets the one-probe-per-cycle pace.
// A clear item invalidates entries by bumping an 8-bit epoch. After reset, and on
// every 255th clear when the epoch wraps, the block sweeps all 131072 slots of the
// slot RAM with s_axis_tready low. Ids start at 1 and run to 65535; a new pair after
// that returns table_full. The result register lets a finished result wait for
// m_axis_tready while the next item is accepted.
module child_path_intern_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [15:0] parent_path, [31:16] segment_id
  input  logic [0:0]  s_axis_tuser,  // [0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [15:0] path_id
  output logic [1:0]  m_axis_tuser   // [0] created, [1] table_full
);
  import cpit_pkg::*;

  logic [KEY_W-1:0]   key;
  logic [SLOT_AW-1:0] hash_slot;
  ram_req_t           ram_req;
  stat_t              stat;
  logic [$bits(slot_t)-1:0] rd_data;
  logic               created, full;

  // key is parent in the upper half, segment in the lower half
  assign key = {s_axis_tdata[15:0], s_axis_tdata[31:16]};

  cpit_hash u_hash (
    .clk  (clk),
    .load (s_axis_tvalid && s_axis_tready),
    .key  (key),
    .slot (hash_slot)
  );

  cpit_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (rd_data)
  );

  cpit_probe u_probe (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .req_type    (s_axis_tuser[0]),
    .key_in      (key),
    .hash_slot   (hash_slot),
    .rd_slot     (slot_t'(rd_data)),
    .ram_req     (ram_req),
    .stat        (stat),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_id      (m_axis_tdata),
    .out_created (created),
    .out_full    (full)
  );

  assign m_axis_tuser = {full, created};

  a_sweep_blocks: assert property (@(posedge clk) disable iff (rst)
    stat.sweeping |-> (!s_axis_tready && ram_req.we))
    else $error("item accepted or no write during slot sweep");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second item accepted while one is in work");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (ram_req.we && ram_req.re) |-> (ram_req.waddr != ram_req.raddr))
    else $error("read and write of the same slot in one cycle");

  a_id_grows: assert property (@(posedge clk) disable iff (rst)
    (ram_req.we && !stat.sweeping) |=> (stat.next_id == $past(stat.next_id) + 1'b1))
    else $error("insert did not advance the next id");

endmodule
